FILE: rtl/slfp_pkg.sv
// Package for the sync/length/type frame parser.
// Parse phases, result kinds and the result beat record. No dependencies.
package slfp_pkg;

    localparam logic [15:0] SYNC_WORD_RESET = 16'h5AA5;
    localparam int          RQ_DEPTH        = 4;
    localparam int          RQ_AW           = 2;

    typedef enum logic [2:0] {
        PH_SYNC0   = 3'd0,
        PH_SYNC1   = 3'd1,
        PH_LEN0    = 3'd2,
        PH_LEN1    = 3'd3,
        PH_TYPE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_IGNORE  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_ACCEPT   = 3'd1,
        KIND_BADSYNC  = 3'd2,
        KIND_HDRTRUNC = 3'd3,
        KIND_PAYTRUNC = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_type;
        logic [15:0] packet_length;
        logic        last;
    } t_result;

    // Up to two result beats caused by one input beat.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

FILE: rtl/sync_length_type_frame_parser_core.sv
// Top level of the sync/length/type frame parser.
// Depends on slfp_pkg, slfp_parse and slfp_resq.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+--------------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_rx_byte, i_end_of_buffer
//  out     | out       | o_out_valid / i_out_stall | o_kind, o_payload_byte,
//          |           |                           | o_packet_type, o_packet_length,
//          |           |                           | o_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_sync_word
//
//  One input byte per cycle while o_in_stall is low; its results enter the result queue
//  on acceptance. Results leave one per cycle from a 4-entry queue while i_out_stall is
//  low, and a byte that makes two results (last or truncated payload byte) takes two entries.
//  o_in_stall rises when fewer than two queue entries are free.
//  Synchronous active-low reset; sync word resets to 0x5AA5; cfg is always ready.
module sync_length_type_frame_parser_core import slfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_packet_type,
    output logic [15:0] o_packet_length,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_sync_word
);

    logic [15:0] r_sync_word;
    logic        in_accept;
    logic        almost_full;
    t_step       step;
    t_result     head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = almost_full;
    assign in_accept   = i_in_valid && !almost_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SYNC_WORD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sync_word <= i_sync_word;
        end
    end

    slfp_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_sync_word     (r_sync_word),
        .o_step          (step)
    );

    slfp_resq u_resq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (in_accept),
        .i_step        (step),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_head        (head),
        .o_almost_full (almost_full)
    );

    assign o_kind          = head.kind;
    assign o_payload_byte  = head.payload_byte;
    assign o_packet_type   = head.packet_type;
    assign o_packet_length = head.packet_length;
    assign o_last          = head.last;

endmodule

FILE: rtl/slfp_parse.sv
// Frame parser state machine: one input beat per cycle while i_accept is high, up to two results.
// Depends on slfp_pkg.
module slfp_parse import slfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_buffer,
    input  logic [15:0] i_sync_word,
    output t_step       o_step
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sync_low;
    logic [15:0] r_length;
    logic [7:0]  r_type;
    logic [15:0] r_remaining;

    logic        bad_sync;
    logic        len_zero;
    logic [15:0] rem_dec;
    logic        rem_zero;

    function automatic t_result mk_result(t_kind kind, logic [7:0] pbyte, logic hdr,
                                          logic [7:0] typ, logic [15:0] len,
                                          logic last);
        t_result r;
        r.kind          = kind;
        r.payload_byte  = pbyte;
        r.packet_type   = hdr ? typ : 8'd0;
        r.packet_length = hdr ? len : 16'd0;
        r.last          = last;
        return r;
    endfunction

    assign bad_sync = (r_sync_low != i_sync_word[7:0]) || (i_rx_byte != i_sync_word[15:8]);
    assign len_zero = (r_length == 16'd0);
    assign rem_dec  = r_remaining - 16'd1;
    assign rem_zero = (rem_dec == 16'd0);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC0: begin
                n_phase = i_end_of_buffer ? PH_SYNC0 : PH_SYNC1;
            end
            PH_SYNC1: begin
                if (i_end_of_buffer) begin
                    n_phase = PH_SYNC0;
                end else begin
                    n_phase = bad_sync ? PH_IGNORE : PH_LEN0;
                end
            end
            PH_LEN0: begin
                n_phase = i_end_of_buffer ? PH_SYNC0 : PH_LEN1;
            end
            PH_LEN1: begin
                n_phase = i_end_of_buffer ? PH_SYNC0 : PH_TYPE;
            end
            PH_TYPE: begin
                if (i_end_of_buffer) begin
                    n_phase = PH_SYNC0;
                end else begin
                    n_phase = len_zero ? PH_IGNORE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (i_end_of_buffer) begin
                    n_phase = PH_SYNC0;
                end else begin
                    n_phase = rem_zero ? PH_IGNORE : PH_PAYLOAD;
                end
            end
            PH_IGNORE: begin
                n_phase = i_end_of_buffer ? PH_SYNC0 : PH_IGNORE;
            end
            default: begin
                n_phase = PH_SYNC0;
            end
        endcase
    end

    always_comb begin
        o_step       = '0;
        o_step.count = 2'd0;
        unique case (r_phase)
            PH_SYNC0, PH_LEN0, PH_LEN1: begin
                if (i_end_of_buffer) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk_result(KIND_HDRTRUNC, 8'd0, 1'b0, r_type, r_length, 1'b1);
                end
            end
            PH_SYNC1: begin
                if (bad_sync) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk_result(KIND_BADSYNC, 8'd0, 1'b0, r_type, r_length, 1'b1);
                end else if (i_end_of_buffer) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk_result(KIND_HDRTRUNC, 8'd0, 1'b0, r_type, r_length, 1'b1);
                end
            end
            PH_TYPE: begin
                if (len_zero) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk_result(KIND_ACCEPT, 8'd0, 1'b1, i_rx_byte, r_length,
                                             1'b1);
                end else if (i_end_of_buffer) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk_result(KIND_PAYTRUNC, 8'd0, 1'b1, i_rx_byte, r_length,
                                             1'b1);
                end
            end
            PH_PAYLOAD: begin
                if (rem_zero || i_end_of_buffer) begin
                    o_step.count = 2'd2;
                    o_step.res0  = mk_result(KIND_PAYLOAD, i_rx_byte, 1'b1, r_type, r_length,
                                             1'b0);
                    o_step.res1  = mk_result(rem_zero ? KIND_ACCEPT : KIND_PAYTRUNC, 8'd0,
                                             1'b1, r_type, r_length, 1'b1);
                end else begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk_result(KIND_PAYLOAD, i_rx_byte, 1'b1, r_type, r_length,
                                             1'b1);
                end
            end
            default: begin
                o_step.count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC0;
            r_sync_low  <= 8'd0;
            r_length    <= 16'd0;
            r_type      <= 8'd0;
            r_remaining <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            unique case (r_phase)
                PH_SYNC0:   r_sync_low      <= i_rx_byte;
                PH_LEN0:    r_length        <= {8'd0, i_rx_byte};
                PH_LEN1:    r_length[15:8]  <= i_rx_byte;
                PH_TYPE: begin
                    r_type      <= i_rx_byte;
                    r_remaining <= r_length;
                end
                PH_PAYLOAD: r_remaining     <= rem_dec;
                default:    r_remaining     <= r_remaining;
            endcase
        end
    end

endmodule

FILE: rtl/slfp_resq.sv
// Result queue: takes up to two result beats per cycle, delivers one per cycle while i_out_stall is low.
// Depends on slfp_pkg.
module slfp_resq import slfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_step   i_step,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_head,
    output logic    o_almost_full
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr, r_rd;
    logic [RQ_AW:0]   r_cnt;
    logic [1:0]       push_n;
    logic             pop;
    logic [RQ_AW-1:0] wr_next;

    assign push_n        = i_push ? i_step.count : 2'd0;
    assign pop           = (r_cnt != '0) && !i_out_stall;
    assign wr_next       = r_wr + RQ_AW'(1);
    assign o_out_valid   = (r_cnt != '0);
    assign o_head        = r_mem[r_rd];
    assign o_almost_full = (r_cnt > (RQ_AW+1)'(RQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_step.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_next] <= i_step.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + RQ_AW'(push_n);
            r_rd  <= r_rd + RQ_AW'(pop);
            r_cnt <= r_cnt + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
        end
    end

endmodule

FILE: rtl/slfp_chk.sv
// Port-level checker for the frame parser core, bound to the top level.
// Depends on slfp_pkg.
module slfp_chk import slfp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_packet_type,
    input logic [15:0] o_packet_length,
    input logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_last))
        else $error("stalled result beat changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= KIND_PAYTRUNC)
        else $error("result kind out of range");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_PAYLOAD) |-> (o_payload_byte == 8'd0) && o_last)
        else $error("non-payload result with byte or without last");

    a_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_BADSYNC || o_kind == KIND_HDRTRUNC)
            |-> (o_packet_type == 8'd0) && (o_packet_length == 16'd0))
        else $error("header fields set before header complete");

endmodule

bind sync_length_type_frame_parser_core slfp_chk u_chk (.*);
